// ----- hw/rtl/spar_pkg.sv -----
// spar_pkg: types and fixed constants of the sweep point average and ratio block
// no dependencies
`timescale 1ns / 1ps
package spar_pkg;
	localparam int W_SUM = 40;
	localparam int W_ACC = 82;
	localparam int W_DEN = 81;
	localparam int W_RES = 48;
	localparam int W_LIM = 17;

	localparam logic [1:0] REG_VPP = 2'd0;
	localparam logic [1:0] REG_PTS = 2'd1;
	localparam logic [1:0] REG_REFDIS = 2'd2;

	localparam logic signed [W_RES-1:0] POS48 = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [W_RES-1:0] NEG48 = 48'sh8000_0000_0000;

	typedef struct packed {
		logic [10:0] point_index;
		logic signed [31:0] fwd_a_re;
		logic signed [31:0] fwd_a_im;
		logic signed [31:0] rev_a_re;
		logic signed [31:0] rev_a_im;
		logic signed [31:0] fwd_b_re;
		logic signed [31:0] fwd_b_im;
		logic signed [31:0] rev_b_re;
		logic signed [31:0] rev_b_im;
	} spar_in_t;

	typedef struct packed {
		logic [9:0] done_index;
		logic signed [W_RES-1:0] refl_re;
		logic signed [W_RES-1:0] refl_im;
		logic signed [W_RES-1:0] thru_re;
		logic signed [W_RES-1:0] thru_im;
		logic sweep_end;
		logic ref_zero;
	} spar_out_t;

	typedef struct packed {
		logic start;
		logic signed [W_ACC-1:0] num;
		logic [W_DEN-1:0] den;
	} spar_div_req_t;

	typedef struct packed {
		logic done;
		logic signed [W_RES-1:0] quo;
	} spar_div_rsp_t;
endpackage

// ----- hw/rtl/spar_if.sv -----
// spar channel interfaces: sample, result and configuration write
// depends on spar_pkg
`timescale 1ns / 1ps
interface spar_in_if import spar_pkg::*; ();
	logic valid;
	logic ready;
	spar_in_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface spar_out_if import spar_pkg::*; ();
	logic valid;
	logic ready;
	spar_out_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface spar_cfg_if ();
	logic valid;
	logic ready;
	logic [1:0] index;
	logic [10:0] data;
	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/spar_div.sv -----
// spar_div: restoring divider, one quotient bit a cycle, signed scaled and saturated result
// depends on spar_pkg
`timescale 1ns / 1ps
module spar_div import spar_pkg::*; #(
	parameter int FRAC_BITS = 20
) (
	input logic clk,
	input logic arst_n,
	input spar_div_req_t req,
	output spar_div_rsp_t rsp
);
	localparam int NUMW = W_ACC - 1 + FRAC_BITS;
	localparam int CNTW = $clog2(NUMW);

	logic busy_q;
	logic done_q;
	logic neg_q;
	logic [CNTW-1:0] cnt_q;
	logic [NUMW-1:0] num_q;
	logic [NUMW-1:0] quo_q;
	logic [W_DEN-1:0] rem_q;
	logic [W_DEN-1:0] den_q;
	logic signed [W_RES-1:0] res_q;
	logic [W_ACC-2:0] mag;
	logic [W_DEN:0] rem_sh;
	logic ge;
	logic [NUMW-1:0] quo_nx;
	logic ovf_pos, ovf_neg;
	logic signed [W_RES-1:0] sat_res;

	assign rsp.done = done_q;
	assign rsp.quo = res_q;

	always_comb begin
		mag = req.num[W_ACC-1] ? (W_ACC-1)'(-req.num) : req.num[W_ACC-2:0];
		rem_sh = {rem_q, num_q[NUMW-1]};
		ge = rem_sh >= {1'b0, den_q};
		quo_nx = {quo_q[NUMW-2:0], ge};
		ovf_pos = |quo_nx[NUMW-1:W_RES-1];
		ovf_neg = (|quo_nx[NUMW-1:W_RES]) || (quo_nx[W_RES-1] && |quo_nx[W_RES-2:0]);
		if (neg_q) begin
			sat_res = ovf_neg ? NEG48 : -$signed(quo_nx[W_RES-1:0]);
		end else begin
			sat_res = ovf_pos ? POS48 : $signed(quo_nx[W_RES-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= busy_q && !req.start && (cnt_q == '0);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= CNTW'(NUMW - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			neg_q <= req.num[W_ACC-1];
			num_q <= {mag, {FRAC_BITS{1'b0}}};
			den_q <= req.den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NUMW-2:0], 1'b0};
			rem_q <= ge ? W_DEN'(rem_sh - {1'b0, den_q}) : rem_sh[W_DEN-1:0];
			quo_q <= quo_nx;
			if (cnt_q == '0) begin
				res_q <= sat_res;
			end
		end
	end
endmodule

// ----- hw/rtl/sweep_point_average_ratio.sv -----
// sweep_point_average_ratio: top level, running sums, point counting and ratio sequencer
// depends on spar_pkg, spar_if and spar_div
`timescale 1ns / 1ps
// Each sample transfer adds its eight wave components to 40-bit running sums and
// counts samples per frequency index. A completed point with the reference
// disabled or a zero reference skips the ratio steps and goes straight to the
// hand-over. A ratio point runs on one shared 40x21 multiplier (each 40x40
// product in a low and a high half, ten products) and one restoring divider that
// yields one quotient bit per cycle over 81+FRAC_BITS bits, four divisions in
// turn. The sample side is not ready until the point has been handed to the
// result register; the result register holds one finished point while the next
// samples come in.
module sweep_point_average_ratio import spar_pkg::*; #(
	parameter int MAX_POINTS = 1024,
	parameter int MAX_AVERAGE = 255,
	parameter int FRAC_BITS = 20
) (
	input logic clk,
	input logic arst_n,
	spar_in_if.sink sample,
	spar_out_if.source result,
	spar_cfg_if.sink cfg
);
	// sequencer states
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DEN = 3'd1;
	localparam logic [2:0] ST_NUM = 3'd2;
	localparam logic [2:0] ST_DIV = 3'd3;
	localparam logic [2:0] ST_FIN = 3'd4;

	// how a point is reported
	localparam logic [1:0] MODE_RATIO = 2'd0;
	localparam logic [1:0] MODE_RAW = 2'd1;
	localparam logic [1:0] MODE_SAT = 2'd2;

	// configuration
	logic [7:0] vpp_q;
	logic [10:0] pts_q;
	logic refdis_q;

	// running state
	logic signed [W_SUM-1:0] sums_q [8];
	logic signed [W_SUM-1:0] sums_nx [8];
	logic [10:0] last_idx_q;
	logic last_vld_q;
	logic [7:0] count_q;

	logic [2:0] state_q;
	logic [1:0] mode_q;
	logic [1:0] mc_q;
	logic [1:0] part_q;
	logic [9:0] idx_q;
	logic end_q;
	logic [W_DEN-1:0] den_q;
	logic signed [W_ACC-1:0] acc_q;
	logic signed [W_RES-1:0] res_q [4];

	logic out_vld_q;
	spar_out_t out_q;

	// accept-time decisions
	logic acc_in;
	logic [W_LIM-1:0] pts_lim;
	logic [7:0] vpp_lim;
	logic in_range;
	logic new_idx;
	logic [7:0] count_nx;
	logic emit;

	// shared multiply-accumulate
	logic signed [W_SUM-1:0] op_a, op_b, mul_x, mul_y;
	logic signed [20:0] y_half;
	logic signed [60:0] prod;
	logic signed [W_ACC-1:0] term, base, acc_nx;
	logic sub;

	spar_div_req_t div_req;
	spar_div_rsp_t div_rsp;

	assign sample.ready = (state_q == ST_IDLE);
	assign acc_in = sample.valid && sample.ready;
	assign cfg.ready = 1'b1;
	assign result.valid = out_vld_q;
	assign result.data = out_q;

	always_comb begin
		sums_nx[0] = sums_q[0] + W_SUM'(sample.data.fwd_a_re);
		sums_nx[1] = sums_q[1] + W_SUM'(sample.data.fwd_a_im);
		sums_nx[2] = sums_q[2] + W_SUM'(sample.data.rev_a_re);
		sums_nx[3] = sums_q[3] + W_SUM'(sample.data.rev_a_im);
		sums_nx[4] = sums_q[4] + W_SUM'(sample.data.fwd_b_re);
		sums_nx[5] = sums_q[5] + W_SUM'(sample.data.fwd_b_im);
		sums_nx[6] = sums_q[6] + W_SUM'(sample.data.rev_b_re);
		sums_nx[7] = sums_q[7] + W_SUM'(sample.data.rev_b_im);

		// limits from the module parameters
		pts_lim = ({6'd0, pts_q} > W_LIM'(MAX_POINTS)) ? W_LIM'(MAX_POINTS)
			: {6'd0, pts_q};
		vpp_lim = ({5'd0, vpp_q} > 13'(MAX_AVERAGE)) ? 8'(MAX_AVERAGE) : vpp_q;
		in_range = {6'd0, sample.data.point_index} < pts_lim;
		new_idx = !last_vld_q || (sample.data.point_index != last_idx_q);
		if (new_idx) begin
			count_nx = 8'd0;
		end else if (count_q != 8'hFF) begin
			count_nx = count_q + 8'd1;
		end else begin
			count_nx = count_q;
		end
		emit = in_range && (vpp_lim != 8'd0) && (count_nx == vpp_lim - 8'd1);
	end

	// operand selection: denominator c*c + d*d, then per part a*c +/- b*d style pairs
	always_comb begin
		op_a = part_q[1] ? sums_q[6] : sums_q[2];
		op_b = part_q[1] ? sums_q[7] : sums_q[3];
		if (state_q == ST_DEN) begin
			mul_x = mc_q[1] ? sums_q[1] : sums_q[0];
			mul_y = mul_x;
			sub = 1'b0;
		end else if (!mc_q[1]) begin
			mul_x = part_q[0] ? op_b : op_a;
			mul_y = sums_q[0];
			sub = 1'b0;
		end else begin
			mul_x = part_q[0] ? op_a : op_b;
			mul_y = sums_q[1];
			sub = part_q[0];
		end
		// low half unsigned, high half signed
		y_half = mc_q[0] ? {mul_y[W_SUM-1], mul_y[W_SUM-1:20]} : {1'b0, mul_y[19:0]};
		prod = mul_x * y_half;
		term = {{(W_ACC-61){prod[60]}}, prod};
		if (mc_q[0]) begin
			term = term <<< 20;
		end
		base = (mc_q == 2'd0) ? '0 : acc_q;
		acc_nx = sub ? base - term : base + term;

		div_req.start = (state_q == ST_NUM) && (mc_q == 2'd3);
		div_req.num = acc_nx;
		div_req.den = den_q;
	end

	spar_div #(
		.FRAC_BITS(FRAC_BITS)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(div_req),
		.rsp(div_rsp)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vpp_q <= 8'd2;
			pts_q <= 11'd101;
			refdis_q <= 1'b0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_VPP: vpp_q <= cfg.data[7:0];
				REG_PTS: pts_q <= cfg.data;
				REG_REFDIS: refdis_q <= cfg.data[0];
				default: ;
			endcase
		end
	end

	function automatic logic signed [W_RES-1:0] sat_sign(logic signed [W_SUM-1:0] s);
		logic signed [W_RES-1:0] r;
		if (s == '0) begin
			r = '0;
		end else begin
			r = s[W_SUM-1] ? NEG48 : POS48;
		end
		return r;
	endfunction

	// sequencer and running state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mode_q <= MODE_RATIO;
			mc_q <= 2'd0;
			part_q <= 2'd0;
			last_vld_q <= 1'b0;
			last_idx_q <= '0;
			count_q <= '0;
			out_vld_q <= 1'b0;
			den_q <= '0;
			acc_q <= '0;
			for (int j = 0; j < 8; j++) begin
				sums_q[j] <= '0;
			end
			for (int j = 0; j < 4; j++) begin
				res_q[j] <= '0;
			end
		end else begin
			// result register fills on hand-over, empties on transfer
			if (state_q == ST_FIN && (!out_vld_q || result.ready)) begin
				out_vld_q <= 1'b1;
			end else if (result.ready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (acc_in) begin
						for (int j = 0; j < 8; j++) begin
							sums_q[j] <= sums_nx[j];
						end
						if (in_range) begin
							count_q <= count_nx;
							last_idx_q <= sample.data.point_index;
							last_vld_q <= 1'b1;
						end
						mc_q <= 2'd0;
						part_q <= 2'd0;
						if (emit) begin
							if (refdis_q) begin
								mode_q <= MODE_RAW;
								state_q <= ST_FIN;
							end else if (sums_nx[0] == '0 && sums_nx[1] == '0) begin
								mode_q <= MODE_SAT;
								state_q <= ST_FIN;
							end else begin
								mode_q <= MODE_RATIO;
								state_q <= ST_DEN;
							end
						end
					end
				end
				ST_DEN: begin
					acc_q <= acc_nx;
					mc_q <= mc_q + 2'd1;
					if (mc_q == 2'd3) begin
						den_q <= acc_nx[W_DEN-1:0];
						state_q <= ST_NUM;
					end
				end
				ST_NUM: begin
					acc_q <= acc_nx;
					mc_q <= mc_q + 2'd1;
					if (mc_q == 2'd3) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						res_q[part_q] <= div_rsp.quo;
						if (part_q == 2'd3) begin
							state_q <= ST_FIN;
						end else begin
							part_q <= part_q + 2'd1;
							state_q <= ST_NUM;
						end
					end
				end
				ST_FIN: begin
					// hand over once the result register is free, then clear the sums
					if (!out_vld_q || result.ready) begin
						state_q <= ST_IDLE;
						for (int j = 0; j < 8; j++) begin
							sums_q[j] <= '0;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && acc_in) begin
			idx_q <= sample.data.point_index[9:0];
			end_q <= ({6'd0, sample.data.point_index} == pts_lim - W_LIM'(1));
		end
		if (state_q == ST_FIN && (!out_vld_q || result.ready)) begin
			out_q.done_index <= idx_q;
			out_q.sweep_end <= end_q;
			out_q.ref_zero <= (mode_q == MODE_SAT);
			case (mode_q)
				MODE_RAW: begin
					out_q.refl_re <= W_RES'(sums_q[2]);
					out_q.refl_im <= W_RES'(sums_q[3]);
					out_q.thru_re <= W_RES'(sums_q[6]);
					out_q.thru_im <= W_RES'(sums_q[7]);
				end
				MODE_SAT: begin
					out_q.refl_re <= sat_sign(sums_q[2]);
					out_q.refl_im <= sat_sign(sums_q[3]);
					out_q.thru_re <= sat_sign(sums_q[6]);
					out_q.thru_im <= sat_sign(sums_q[7]);
				end
				default: begin
					out_q.refl_re <= res_q[0];
					out_q.refl_im <= res_q[1];
					out_q.thru_re <= res_q[2];
					out_q.thru_im <= res_q[3];
				end
			endcase
		end
	end

	// a completed point holds off the next sample
	a_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		acc_in && emit |=> !sample.ready)
		else $error("sample taken while point in progress");

	// never divide by a zero reference
	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> den_q != '0)
		else $error("division with zero denominator");

	// zero reference only gives saturated or zero parts
	a_ref_zero_sat: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.data.ref_zero |->
			(result.data.refl_re == '0 || result.data.refl_re == POS48
			|| result.data.refl_re == NEG48))
		else $error("zero reference with unsaturated ratio");
endmodule

// ----- bench/testbench.sv -----
// testbench: self-checking bench for sweep_point_average_ratio
// depends on spar_pkg and the spar_if channel interfaces of the rtl
`timescale 1ns / 1ps
module testbench;
	import spar_pkg::*;

	localparam int STALL_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 600;

	logic clk;
	logic arst_n;

	spar_in_if sample_ch ();
	spar_out_if result_ch ();
	spar_cfg_if cfg_ch ();

	sweep_point_average_ratio dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample(sample_ch),
		.result(result_ch),
		.cfg(cfg_ch)
	);

	// samples waiting for the driver, and finished points still to come out
	spar_in_t sample_queue[$];
	spar_out_t points_due[$];

	// own copy of the block state and its register settings
	logic signed [39:0] run_sum[8];
	logic [10:0] prev_index;
	logic prev_index_seen;
	logic [7:0] count_at_index;
	logic [7:0] avg_setting;
	logic [10:0] sweep_len;
	logic raw_mode;

	int idle_pct;
	int stall_pct;
	int errors;
	int quiet_cycles;
	logic sample_took;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic report(input string what, input logic [47:0] got, input logic [47:0] want);
		$display("mismatch %s: got %h want %h", what, got, want);
		errors++;
	endtask

	function automatic logic signed [31:0] wave_of(input spar_in_t s, input int j);
		case (j)
			0: return s.fwd_a_re;
			1: return s.fwd_a_im;
			2: return s.rev_a_re;
			3: return s.rev_a_im;
			4: return s.fwd_b_re;
			5: return s.fwd_b_im;
			6: return s.rev_b_re;
			default: return s.rev_b_im;
		endcase
	endfunction

	// numerator scaled by the fraction bits, truncated toward zero, then clipped
	function automatic logic signed [47:0] scaled_quotient(input logic signed [127:0] num,
			input logic signed [127:0] den);
		logic signed [127:0] q;
		logic signed [127:0] top;
		top = 128'sh7FFF_FFFF_FFFF;
		q = (num <<< 20) / den;
		if (q > top) return POS48;
		if (q < -top - 1) return NEG48;
		return q[47:0];
	endfunction

	function automatic logic signed [47:0] clip_sign(input logic signed [39:0] v);
		if (v == 0) return '0;
		return v < 0 ? NEG48 : POS48;
	endfunction

	// one sample through the averaging stage; returns 1 when a point completes
	function automatic bit average_sample(input spar_in_t s, output spar_out_t p);
		logic [10:0] pts_eff;
		logic [7:0] vpp_eff;
		logic signed [127:0] c, d, a, b, den;
		logic signed [31:0] w;
		p = '0;
		pts_eff = sweep_len > 1024 ? 11'd1024 : sweep_len;
		vpp_eff = avg_setting;
		for (int j = 0; j < 8; j++) begin
			w = wave_of(s, j);
			run_sum[j] = run_sum[j] + {{8{w[31]}}, w};
		end
		if (s.point_index >= pts_eff) return 0;
		if (!prev_index_seen || s.point_index != prev_index) begin
			count_at_index = 0;
			prev_index = s.point_index;
			prev_index_seen = 1'b1;
		end else if (count_at_index != 8'd255) begin
			count_at_index++;
		end
		if (vpp_eff == 0 || count_at_index != vpp_eff - 8'd1) return 0;
		p.done_index = s.point_index[9:0];
		p.sweep_end = s.point_index == pts_eff - 11'd1;
		if (raw_mode) begin
			p.refl_re = 48'(run_sum[2]);
			p.refl_im = 48'(run_sum[3]);
			p.thru_re = 48'(run_sum[6]);
			p.thru_im = 48'(run_sum[7]);
		end else if (run_sum[0] == 0 && run_sum[1] == 0) begin
			// zero reference: each part pinned by the sign of its reverse sum
			p.refl_re = clip_sign(run_sum[2]);
			p.refl_im = clip_sign(run_sum[3]);
			p.thru_re = clip_sign(run_sum[6]);
			p.thru_im = clip_sign(run_sum[7]);
			p.ref_zero = 1'b1;
		end else begin
			c = run_sum[0];
			d = run_sum[1];
			den = c * c + d * d;
			a = run_sum[2];
			b = run_sum[3];
			p.refl_re = scaled_quotient(a * c + b * d, den);
			p.refl_im = scaled_quotient(b * c - a * d, den);
			a = run_sum[6];
			b = run_sum[7];
			p.thru_re = scaled_quotient(a * c + b * d, den);
			p.thru_im = scaled_quotient(b * c - a * d, den);
		end
		for (int j = 0; j < 8; j++) run_sum[j] = '0;
		return 1;
	endfunction

	// sample driver: new values at the falling edge, held until the transfer
	always @(negedge clk) begin
		if (!arst_n) begin
			sample_ch.valid <= 1'b0;
		end else if (sample_ch.valid && !sample_took) begin
			// hold the pending transfer
		end else if (sample_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
			sample_ch.valid <= 1'b1;
			sample_ch.data <= sample_queue.pop_front();
		end else begin
			sample_ch.valid <= 1'b0;
		end
		result_ch.ready <= arst_n && ($urandom_range(99) >= stall_pct);
	end

	// monitor: checks finished points, then runs accepted samples through the predictor
	always @(posedge clk) begin
		spar_out_t want;
		spar_out_t got;
		spar_out_t made;
		sample_took <= sample_ch.valid && sample_ch.ready;
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready) begin
				got = result_ch.data;
				if (points_due.size() == 0) begin
					report("unexpected point", 48'(got.done_index), '0);
				end else begin
					want = points_due.pop_front();
					if (got.done_index != want.done_index)
						report("done_index", 48'(got.done_index), 48'(want.done_index));
					if (got.refl_re != want.refl_re) report("refl_re", got.refl_re, want.refl_re);
					if (got.refl_im != want.refl_im) report("refl_im", got.refl_im, want.refl_im);
					if (got.thru_re != want.thru_re) report("thru_re", got.thru_re, want.thru_re);
					if (got.thru_im != want.thru_im) report("thru_im", got.thru_im, want.thru_im);
					if (got.sweep_end != want.sweep_end)
						report("sweep_end", 48'(got.sweep_end), 48'(want.sweep_end));
					if (got.ref_zero != want.ref_zero)
						report("ref_zero", 48'(got.ref_zero), 48'(want.ref_zero));
				end
			end
			if (sample_ch.valid && sample_ch.ready) begin
				if (average_sample(sample_ch.data, made)) points_due = {points_due, made};
			end
			if (cfg_ch.valid && cfg_ch.ready) begin
				case (cfg_ch.index)
					REG_VPP: avg_setting = cfg_ch.data[7:0];
					REG_PTS: sweep_len = cfg_ch.data;
					REG_REFDIS: raw_mode = cfg_ch.data[0];
					default: ;
				endcase
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [10:0] value);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic logic [31:0] pick_wave(input int mode);
		case (mode)
			0: return $urandom;
			1: return 32'($urandom_range(2000)) - 32'd1000;
			default:
				case ($urandom_range(4))
					0: return 32'h7FFF_FFFF;
					1: return 32'h8000_0000;
					2: return 32'hFFFF_FFFF;
					3: return 32'd1;
					default: return 32'd0;
				endcase
		endcase
	endfunction

	// n samples at one index; mode 3 keeps the port one forward wave at zero
	task automatic queue_point(input logic [10:0] idx, input int n, input int mode);
		spar_in_t s;
		for (int k = 0; k < n; k++) begin
			s.point_index = idx;
			s.fwd_a_re = mode == 3 ? '0 : pick_wave(mode % 3);
			s.fwd_a_im = mode == 3 ? '0 : pick_wave(mode % 3);
			s.rev_a_re = pick_wave(mode % 3);
			s.rev_a_im = pick_wave(mode % 3);
			s.fwd_b_re = pick_wave(mode % 3);
			s.fwd_b_im = pick_wave(mode % 3);
			s.rev_b_re = pick_wave(mode % 3);
			s.rev_b_im = pick_wave(mode % 3);
			sample_queue = {sample_queue, s};
		end
	endtask

	task automatic queue_fixed(input logic [10:0] idx, input logic [31:0] v, input int n);
		spar_in_t s;
		s = {idx, {8{v}}};
		repeat (n) sample_queue = {sample_queue, s};
	endtask

	// mostly whole points with random content, some broken points and stray indices
	task automatic queue_random(input int total);
		int made;
		int r;
		int n;
		logic [10:0] pts_eff;
		logic [10:0] idx;
		made = 0;
		while (made < total) begin
			r = $urandom_range(99);
			pts_eff = sweep_len > 1024 ? 11'd1024 : sweep_len;
			if (pts_eff == 0 || r < 6) begin
				idx = 11'($urandom_range(2047));
				n = 1;
			end else begin
				idx = r < 15 ? pts_eff - 11'd1 : 11'($urandom_range(pts_eff - 1));
				if (avg_setting == 0) n = $urandom_range(1, 4);
				else if (r < 85) n = int'(avg_setting);
				else n = $urandom_range(1, avg_setting + 1);
			end
			queue_point(idx, n, $urandom_range(3));
			made += n;
		end
	endtask

	// let every queued sample go, collect every point, then let the block settle
	task automatic drain;
		while (sample_queue.size() != 0 || sample_ch.valid) @(posedge clk);
		while (points_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic random_phase(input logic [7:0] vpp, input logic [10:0] pts, input logic refdis,
			input int idle, input int stall, input int total);
		write_reg(REG_VPP, 11'(vpp));
		write_reg(REG_PTS, pts);
		write_reg(REG_REFDIS, 11'(refdis));
		idle_pct = idle;
		stall_pct = stall;
		queue_random(total);
		drain();
	endtask

	initial begin
		errors = 0;
		quiet_cycles = 0;
		idle_pct = 0;
		stall_pct = 0;
		sample_took = 1'b0;
		sample_ch.valid = 1'b0;
		sample_ch.data = '0;
		result_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_VPP;
		cfg_ch.data = '0;
		for (int j = 0; j < 8; j++) run_sum[j] = '0;
		prev_index = '0;
		prev_index_seen = 1'b0;
		count_at_index = '0;
		avg_setting = 8'd2;
		sweep_len = 11'd101;
		raw_mode = 1'b0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part on the reset settings
		queue_fixed(11'd0, 32'h7FFF_FFFF, 2);
		queue_fixed(11'd1, 32'h8000_0000, 2);
		queue_point(11'd2, 2, 3);
		queue_fixed(11'd3, 32'd0, 2);
		queue_fixed(11'd100, 32'hFFFF_FFFF, 2);
		queue_fixed(11'd2047, 32'h7FFF_FFFF, 1);
		queue_fixed(11'd101, 32'd1, 1);
		// repeated index keeps counting after its point, then a new index restarts
		queue_point(11'd5, 3, 0);
		queue_point(11'd6, 1, 1);
		queue_point(11'd7, 2, 2);
		queue_point(11'd4, 2, 3);
		drain();

		// register sweeps, each with an idling and stall mix of its own settings
		random_phase(8'd1, 11'd1024, 1'b0, 0, 0, 200);
		random_phase(8'd3, 11'd5, 1'b1, 58, 0, 180);
		random_phase(8'd2, 11'd1, 1'b0, 0, 58, 180);
		random_phase(8'd255, 11'd2047, 1'b0, 21, 21, 400);
		random_phase(8'd0, 11'd0, 1'b1, 0, 0, 40);
		random_phase(8'd4, 11'd16, 1'b0, 21, 21, 180);

		if (errors == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end
endmodule
